// File: sv/aasa_pkg.sv
`default_nettype none

package aasa_pkg;

    // Opcodes handled by the block
    localparam logic [7:0] OP_NOP    = 8'h00;
    localparam logic [7:0] OP_LXI_B  = 8'h01;
    localparam logic [7:0] OP_MOV_BC = 8'h41;
    localparam logic [7:0] OP_MOV_BE = 8'h43;
    localparam logic [7:0] OP_ALU_LO = 8'h80;
    localparam logic [7:0] OP_ALU_HI = 8'h9f;
    localparam logic [7:0] OP_ADI    = 8'hc6;
    localparam logic [7:0] OP_ACI    = 8'hce;
    localparam logic [7:0] OP_SUI    = 8'hd6;
    localparam logic [7:0] OP_SBI    = 8'hde;

    // ALU operation, taken from opcode bits 4:3
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_ADC = 2'd1;
    localparam logic [1:0] ALU_SUB = 2'd2;
    localparam logic [1:0] ALU_SBB = 2'd3;

    // Source register codes, opcode bits 2:0
    localparam logic [2:0] SRC_B = 3'd0;
    localparam logic [2:0] SRC_C = 3'd1;
    localparam logic [2:0] SRC_D = 3'd2;
    localparam logic [2:0] SRC_E = 3'd3;
    localparam logic [2:0] SRC_H = 3'd4;
    localparam logic [2:0] SRC_L = 3'd5;
    localparam logic [2:0] SRC_M = 3'd6;
    localparam logic [2:0] SRC_A = 3'd7;

    // Instruction lengths in bytes
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic zero;
        logic sign;
        logic parity;
        logic carry;
    } flags_t;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] operand_low;
        logic [7:0] operand_high;
        logic [7:0] mem_at_hl;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  acc_value;
        logic [7:0]  reg_b_value;
        logic [7:0]  reg_c_value;
        logic        zero_flag;
        logic        sign_flag;
        logic        parity_flag;
        logic        carry_flag;
        logic [15:0] hl_address;
        logic [1:0]  instr_length;
        logic        handled;
    } out_item_t;

endpackage

`default_nettype wire

// File: sv/aasa_alu.sv
`default_nettype none

module aasa_alu (
    input  wire logic [1:0]    op,
    input  wire logic [7:0]    acc,
    input  wire logic [7:0]    operand,
    input  wire logic          carry_in,
    output logic [7:0]         result,
    output aasa_pkg::flags_t   flags
);

    logic       cin;
    logic [8:0] sub_val;
    logic [8:0] sum_val;
    logic       cy;

    // Carry-in only for ADC and SBB; for subtraction carry means borrow
    assign cin     = op[0] & carry_in;
    assign sub_val = {1'b0, operand} + {8'd0, cin};
    assign sum_val = {1'b0, acc} + {1'b0, operand} + {8'd0, cin};

    always_comb
    begin
        if (op[1])
        begin
            cy     = ({1'b0, acc} < sub_val);
            result = acc - sub_val[7:0];
        end
        else
        begin
            cy     = sum_val[8];
            result = sum_val[7:0];
        end
    end

    assign flags.zero   = (result == 8'h00);
    assign flags.sign   = result[7];
    assign flags.parity = ~^result;
    assign flags.carry  = cy;

endmodule

`default_nettype wire

// File: sv/accumulator_add_sub_alu_unit.sv
`default_nettype none

// Accumulator ALU of an 8080-style CPU: each input beat carries one opcode, its
// two operand bytes and the memory byte at H:L, and yields one result beat with
// A, B, C, the zero/sign/parity/carry flags, H:L, the instruction length and a
// handled bit. Supported: NOP, LXI B, MOV B,C/D/E, and ADD/ADC/SUB/SBB from a
// register, from memory or from an immediate (ADI/ACI/SUI/SBI); carry holds the
// borrow after a subtract. Any other opcode changes nothing, reports length 1
// and handled 0. The unit takes one instruction per clock while out_ready does not
// stall the output; an accepted beat lands in the input register, then passes
// through the 8-bit adder and flag logic into the result register, which is also
// where the architectural registers update. Back-to-back instructions see each
// other's results without stalls. The memory byte is used as given and is not
// checked against H:L.
module accumulator_add_sub_alu_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire aasa_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output aasa_pkg::out_item_t      out_data
);

    // Input stage
    logic               in_valid_reg;
    aasa_pkg::in_item_t in_data_reg;

    // Result stage
    logic                out_valid_reg;
    aasa_pkg::out_item_t out_data_reg;

    // Architectural state
    logic [7:0]       acc_reg, acc_next;
    logic [7:0]       b_reg, b_next;
    logic [7:0]       c_reg, c_next;
    logic [7:0]       d_reg;
    logic [7:0]       e_reg;
    logic [7:0]       h_reg;
    logic [7:0]       l_reg;
    aasa_pkg::flags_t flags_reg, flags_next;

    logic        advance;
    logic [7:0]  src_byte;
    logic [7:0]  alu_operand;
    logic [7:0]  alu_result;
    logic        use_alu;
    logic [1:0]  len_next;
    logic        handled_next;
    aasa_pkg::flags_t alu_flags;

    // Move the input beat into the result stage when that stage is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (in_data_reg.cmd[2:0])
            aasa_pkg::SRC_B: src_byte = b_reg;
            aasa_pkg::SRC_C: src_byte = c_reg;
            aasa_pkg::SRC_D: src_byte = d_reg;
            aasa_pkg::SRC_E: src_byte = e_reg;
            aasa_pkg::SRC_H: src_byte = h_reg;
            aasa_pkg::SRC_L: src_byte = l_reg;
            aasa_pkg::SRC_M: src_byte = in_data_reg.mem_at_hl;
            aasa_pkg::SRC_A: src_byte = acc_reg;
            default:         src_byte = acc_reg;
        endcase
    end

    aasa_alu u_alu (
        .op       (in_data_reg.cmd[4:3]),
        .acc      (acc_reg),
        .operand  (alu_operand),
        .carry_in (flags_reg.carry),
        .result   (alu_result),
        .flags    (alu_flags)
    );

    // Instruction decode: pick the operand, the next state and the length
    always_comb
    begin
        b_next       = b_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        flags_next   = flags_reg;
        alu_operand  = src_byte;
        use_alu      = 1'b0;
        len_next     = aasa_pkg::LEN_ONE;
        handled_next = 1'b1;
        unique case (in_data_reg.cmd) inside
            aasa_pkg::OP_NOP:
            begin
            end
            aasa_pkg::OP_LXI_B:
            begin
                b_next   = in_data_reg.operand_high;
                c_next   = in_data_reg.operand_low;
                len_next = aasa_pkg::LEN_THREE;
            end
            [aasa_pkg::OP_MOV_BC : aasa_pkg::OP_MOV_BE]:
            begin
                b_next = src_byte;
            end
            [aasa_pkg::OP_ALU_LO : aasa_pkg::OP_ALU_HI]:
            begin
                use_alu = 1'b1;
            end
            aasa_pkg::OP_ADI, aasa_pkg::OP_ACI, aasa_pkg::OP_SUI, aasa_pkg::OP_SBI:
            begin
                alu_operand = in_data_reg.operand_low;
                use_alu     = 1'b1;
                len_next    = aasa_pkg::LEN_TWO;
            end
            default:
            begin
                handled_next = 1'b0;
            end
        endcase
        if (use_alu)
        begin
            acc_next   = alu_result;
            flags_next = alu_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 8'h00;
            b_reg         <= 8'h00;
            c_reg         <= 8'h00;
            d_reg         <= 8'h00;
            e_reg         <= 8'h00;
            h_reg         <= 8'h00;
            l_reg         <= 8'h00;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                b_reg         <= b_next;
                c_reg         <= c_next;
                flags_reg     <= flags_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture on handshake, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg.acc_value    <= acc_next;
            out_data_reg.reg_b_value  <= b_next;
            out_data_reg.reg_c_value  <= c_next;
            out_data_reg.zero_flag    <= flags_next.zero;
            out_data_reg.sign_flag    <= flags_next.sign;
            out_data_reg.parity_flag  <= flags_next.parity;
            out_data_reg.carry_flag   <= flags_next.carry;
            out_data_reg.hl_address   <= {h_reg, l_reg};
            out_data_reg.instr_length <= len_next;
            out_data_reg.handled      <= handled_next;
        end
    end

`ifndef SYNTHESIS
    // An unknown opcode must leave A and the flags untouched
    a_unhandled_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !handled_next |=> $stable(acc_reg) && $stable(flags_reg))
        else $error("unhandled opcode changed A or flags");

    // An unknown opcode reports a one-byte instruction
    a_unhandled_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.handled |-> out_data.instr_length == aasa_pkg::LEN_ONE)
        else $error("unhandled opcode with length other than one");

    // The result beat mirrors the state just written
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_data.acc_value == acc_reg && out_data.reg_b_value == b_reg
                    && out_data.carry_flag == flags_reg.carry)
        else $error("result beat differs from updated state");

    // An empty input stage always takes a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire
